>>> design/mbe_pkg.sv
// Shared types and constants for the Mandelbrot escape counter.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package mbe_pkg;

    // Point and iterate format: signed Q4.28
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 28;
    // Full products of two iterate values
    localparam int PROD_W    = 2 * DATA_W;

    // Result count field and default iteration counter width
    localparam int COUNT_W        = 16;
    localparam int ITER_WIDTH_DEF = 16;
    localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd16;

    // |z|^2 > 8, with 2*FRAC_BITS fraction bits
    localparam logic [PROD_W:0] ESC_LIMIT = (PROD_W + 1)'(8) << (2 * FRAC_BITS);

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_MAX_ITER = 1'b0;   // register index, taken from paddr[2]

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture c and start from z = c
        logic mul;    // form the squares and the cross product of z
        logic adv;    // commit the next z
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic escape; // current z lies outside the escape disc
    } status_t;

endpackage

`default_nettype wire

>>> design/mbe_datapath.sv
// Iteration datapath: point and iterate registers, three 32x32 multipliers,
// next-value adders and the escape compare. Depends on mbe_pkg.
`default_nettype none

module mbe_datapath (
    input  logic                               aclk,
    input  logic signed [mbe_pkg::DATA_W-1:0]  c_real,
    input  logic signed [mbe_pkg::DATA_W-1:0]  c_imag,
    input  mbe_pkg::cmd_t                      cmd,
    output mbe_pkg::status_t                   status
);
    import mbe_pkg::*;

    logic signed [DATA_W-1:0] cr_reg;
    logic signed [DATA_W-1:0] ci_reg;
    logic signed [DATA_W-1:0] zr_reg;
    logic signed [DATA_W-1:0] zi_reg;
    logic signed [PROD_W-1:0] sq_r_reg;
    logic signed [PROD_W-1:0] sq_i_reg;
    logic signed [PROD_W-1:0] cross_reg;
    logic                     ovf_reg;

    logic signed [PROD_W-1:0] diff;
    logic signed [PROD_W-1:0] re_sh;
    logic signed [PROD_W-1:0] im_sh;
    logic signed [PROD_W-1:0] re_next;
    logic signed [PROD_W-1:0] im_next;
    logic [PROD_W-DATA_W:0]   re_top;
    logic [PROD_W-DATA_W:0]   im_top;
    logic                     re_fits;
    logic                     im_fits;
    logic [PROD_W:0]          mag;

    // Squares are at most 2^62, so the difference cannot wrap
    assign diff    = sq_r_reg - sq_i_reg;
    assign re_sh   = diff >>> FRAC_BITS;
    // 2*zr*zi: fold the factor two into the shift
    assign im_sh   = cross_reg >>> (FRAC_BITS - 1);
    assign re_next = re_sh + PROD_W'(cr_reg);
    assign im_next = im_sh + PROD_W'(ci_reg);

    // A value that does not fit Q4.28 has magnitude >= 8 and escapes anyway
    assign re_top  = re_next[PROD_W-1:DATA_W-1];
    assign im_top  = im_next[PROD_W-1:DATA_W-1];
    assign re_fits = (&re_top) | ~(|re_top);
    assign im_fits = (&im_top) | ~(|im_top);

    // Squares of the current z double as the magnitude terms
    assign mag = {1'b0, sq_r_reg} + {1'b0, sq_i_reg};
    assign status.escape = ovf_reg | (mag > ESC_LIMIT);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cr_reg  <= c_real;
            ci_reg  <= c_imag;
            zr_reg  <= c_real;
            zi_reg  <= c_imag;
            ovf_reg <= 1'b0;
        end
        if (cmd.mul) begin
            sq_r_reg  <= zr_reg * zr_reg;
            sq_i_reg  <= zi_reg * zi_reg;
            cross_reg <= zr_reg * zi_reg;
        end
        if (cmd.adv) begin
            zr_reg  <= re_next[DATA_W-1:0];
            zi_reg  <= im_next[DATA_W-1:0];
            ovf_reg <= ~(re_fits & im_fits);
        end
    end

endmodule

`default_nettype wire

>>> design/mbe_ctrl.sv
// Sequencer for the escape iteration: step counter, bound check and the
// result register. Depends on mbe_pkg.
`default_nettype none

module mbe_ctrl #(
    parameter int  ITER_WIDTH = mbe_pkg::ITER_WIDTH_DEF,
    localparam int CNT_W = (ITER_WIDTH < mbe_pkg::COUNT_W) ? ITER_WIDTH : mbe_pkg::COUNT_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mbe_pkg::COUNT_W-1:0]   m_escape_count,
    output logic                          m_escaped,
    input  logic [CNT_W-1:0]              max_iter,
    input  mbe_pkg::status_t              status,
    output mbe_pkg::cmd_t                 cmd
);
    import mbe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD
    } state_t;

    state_t             state_reg;
    logic               first_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               m_valid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               escaped_reg;

    logic [CNT_W-1:0]   cnt_plus;
    logic               test_esc;
    logic               last;
    logic               finish;
    logic               out_free;
    logic               emit;

    assign cnt_plus = cnt_reg + 1'b1;
    // The first add pass only forms z1; no test yet
    assign test_esc = ~first_reg & status.escape;
    assign last     = first_reg ? (max_iter == '0) : (cnt_plus == max_iter);
    assign finish   = test_esc | last;
    assign out_free = ~m_valid_reg | m_ready;
    assign emit     = (state_reg == ST_ADD) & finish & out_free;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_escape_count = count_reg;
    assign m_escaped      = escaped_reg;

    assign cmd.load = s_valid & (state_reg == ST_IDLE);
    assign cmd.mul  = (state_reg == ST_MUL);
    assign cmd.adv  = (state_reg == ST_ADD) & ~finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            first_reg   <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        first_reg <= 1'b1;
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    if (finish) begin
                        // hold here until the result register frees up
                        if (out_free) begin
                            count_reg   <= test_esc ? COUNT_W'(cnt_reg) : COUNT_W'(max_iter);
                            escaped_reg <= test_esc;
                            state_reg   <= ST_IDLE;
                        end
                    end else begin
                        if (!first_reg) begin
                            cnt_reg <= cnt_plus;
                        end
                        first_reg <= 1'b0;
                        state_reg <= ST_MUL;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/mandelbrot_escape_counter_unit.sv
// Top level of the Mandelbrot escape counter: register port, controller and
// datapath. Depends on mbe_pkg, mbe_ctrl and mbe_datapath.
//
// Usage:
//   Input channel (s_valid/s_ready, s_c_real, s_c_imag) takes one point c as
//   signed Q4.28. The unit iterates z = z*z + c from z = c, testing each new
//   z against |z|^2 > 8, for at most max_iter steps.
//   Result channel (m_valid/m_ready, m_escape_count, m_escaped) gives one
//   item per point: the step index at escape, or max_iter with escaped low.
//   Each step passes through the three 32x32 multipliers (ST_MUL) and
//   then through the adders and the escape compare (ST_ADD). A new point
//   is taken only after the result of the last one is registered, and can
//   be taken in the cycle after that.
//   A max_iter of zero returns count 0, escaped 0.
//   A finished result waits in the output register, so s_ready returns while
//   the receiver stalls; a second result holds the sequencer until the
//   register frees up.
//   Reset (aresetn low, synchronous) drops any point in flight, empties the
//   output register and sets max_iter back to 16.
//   max_iter sits at byte address 0 of the register port; write it only
//   while no point is in flight.
`default_nettype none

module mandelbrot_escape_counter_unit #(
    parameter int ITER_WIDTH = mbe_pkg::ITER_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mbe_pkg::PADDR_W-1:0]        paddr,
    input  logic [mbe_pkg::PDATA_W-1:0]        pwdata,
    output logic [mbe_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    // point input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [mbe_pkg::DATA_W-1:0]  s_c_real,
    input  logic signed [mbe_pkg::DATA_W-1:0]  s_c_imag,
    // result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mbe_pkg::COUNT_W-1:0]        m_escape_count,
    output logic                               m_escaped
);
    import mbe_pkg::*;

    // The bound is kept to the narrower of ITER_WIDTH and the count field
    localparam int CNT_W = (ITER_WIDTH < COUNT_W) ? ITER_WIDTH : COUNT_W;

    logic [CNT_W-1:0] max_iter_reg;
    logic             reg_write;
    cmd_t             cmd;
    status_t          status;

    // Register port: no wait states
    assign pready    = 1'b1;
    assign reg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == REG_MAX_ITER) ? PDATA_W'(max_iter_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= CNT_W'(MAX_ITER_RESET);
        end else if (reg_write && paddr[2] == REG_MAX_ITER) begin
            // keep only the bits the counter can hold
            max_iter_reg <= pwdata[CNT_W-1:0];
        end
    end

    mbe_ctrl #(
        .ITER_WIDTH (ITER_WIDTH)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_escape_count (m_escape_count),
        .m_escaped      (m_escaped),
        .max_iter       (max_iter_reg),
        .status         (status),
        .cmd            (cmd)
    );

    mbe_datapath u_datapath (
        .aclk   (aclk),
        .c_real (s_c_real),
        .c_imag (s_c_imag),
        .cmd    (cmd),
        .status (status)
    );

`ifndef SYNTHESIS
    // One point at a time: acceptance closes the input until the result is done
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a point is in flight");

    // An escape is always reported before the bound is reached
    a_escape_below_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_escaped |-> m_escape_count < COUNT_W'(max_iter_reg))
        else $error("escape count not below max_iter");

    // A point that never escapes reports the bound itself
    a_inside_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_escaped |-> m_escape_count == COUNT_W'(max_iter_reg))
        else $error("non-escaped count differs from max_iter");
`endif

endmodule

`default_nettype wire

>>> tb/mbe_checker.sv
// Scoreboard for the Mandelbrot escape counter: watches the register port and
// both item channels, predicts each result and compares it. Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mbe_pkg::PADDR_W-1:0]        paddr,
    input  logic [mbe_pkg::PDATA_W-1:0]        pwdata,
    input  logic [mbe_pkg::PDATA_W-1:0]        prdata,
    input  logic                               pready,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic signed [mbe_pkg::DATA_W-1:0]  s_c_real,
    input  logic signed [mbe_pkg::DATA_W-1:0]  s_c_imag,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [mbe_pkg::COUNT_W-1:0]        m_escape_count,
    input  logic                               m_escaped,
    output int                                 error_count,
    output int                                 pending_count,
    output int                                 result_count,
    output int                                 escaped_count
);
    import mbe_pkg::*;

    localparam logic [PADDR_W-1:0] MAX_ITER_ADDR = {REG_MAX_ITER, 2'b00};
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               escaped;
    } escape_result_t;

    escape_result_t      expected_q[$];
    logic [COUNT_W-1:0]  iter_bound;
    int                  errors;
    int                  results;
    int                  escapes;

    // Escape time of one point: iterate from z = c with exact products and
    // floor shifts, test each new z against |z|^2 > 8.
    function automatic escape_result_t escape_time(input logic signed [DATA_W-1:0] c_re,
                                                   input logic signed [DATA_W-1:0] c_im,
                                                   input logic [COUNT_W-1:0] bound);
        logic signed [127:0] cr, ci, zr, zi, nr, ni, mag_sq, limit;
        escape_result_t      res;
        int unsigned         step;
        cr = c_re;
        ci = c_im;
        zr = cr;
        zi = ci;
        limit = 128'sd8 <<< (2 * FRAC_BITS);
        res.count = bound;
        res.escaped = 1'b0;
        for (step = 0; step < bound && !res.escaped; step++) begin
            nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
            ni = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
            mag_sq = nr * nr + ni * ni;
            if (mag_sq > limit) begin
                res.count = COUNT_W'(step);
                res.escaped = 1'b1;
            end else begin
                zr = nr;
                zi = ni;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        escape_result_t want;
        if (!aresetn) begin
            expected_q.delete();
            iter_bound = MAX_ITER_RESET;
            errors = 0;
            results = 0;
            escapes = 0;
        end else begin
            if (psel && penable && pready && paddr == MAX_ITER_ADDR) begin
                if (pwrite) begin
                    iter_bound = pwdata[COUNT_W-1:0];
                end else if (prdata !== PDATA_W'(iter_bound)) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("[%0t] max_iter read: expected %0d, got %0h",
                                 $realtime, iter_bound, prdata);
                end
            end
            // pop before push: a result never belongs to the item taken at the same edge
            if (m_valid && m_ready) begin
                results++;
                if (m_escaped === 1'b1)
                    escapes++;
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("[%0t] unexpected result: count %0d escaped %0b",
                                 $realtime, m_escape_count, m_escaped);
                end else begin
                    want = expected_q.pop_front();
                    if (m_escape_count !== want.count || m_escaped !== want.escaped) begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display(
                                "[%0t] result %0d: expected %0d escaped %0b, got %0d escaped %0b",
                                $realtime, results, want.count, want.escaped,
                                m_escape_count, m_escaped);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(escape_time(s_c_real, s_c_imag, iter_bound));
        end
        error_count   <= errors;
        pending_count <= expected_q.size();
        result_count  <= results;
        escaped_count <= escapes;
    end

endmodule

>>> tb/testbench.sv
// Top of the Mandelbrot escape counter testbench: clock, reset, register
// writes, point stimulus, result back-pressure and the verdict.
// Depends on mbe_pkg, mandelbrot_escape_counter_unit and mbe_checker.
`timescale 1ns / 1ps

module testbench;
    import mbe_pkg::*;

    // Let a few cycles pass after the last result before touching max_iter;
    // every point yields a result, so nothing can still be in flight.
    localparam int SETTLE_CYCLES = 8;
    // Tail wait before the verdict, sized for one point at the reset bound
    localparam int TAIL_CYCLES = 40;
    // Longest quiet stretch of a correct run: one point at max_iter 65535
    // plus the longest stall on either side, taken ~4x
    localparam int unsigned WATCHDOG_LIMIT = 600_000;
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS = 157;
    localparam logic [PADDR_W-1:0] MAX_ITER_ADDR = {REG_MAX_ITER, 2'b00};

    // Q4.28 landmarks
    localparam logic signed [DATA_W-1:0] ONE     = 32'sh1000_0000;
    localparam logic signed [DATA_W-1:0] TWO     = 32'sh2000_0000;
    localparam logic signed [DATA_W-1:0] HALF    = 32'sh0800_0000;
    localparam logic signed [DATA_W-1:0] QUARTER = 32'sh0400_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN   = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } point_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [DATA_W-1:0]  s_c_real = '0;
    logic signed [DATA_W-1:0]  s_c_imag = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [COUNT_W-1:0]        m_escape_count;
    logic                      m_escaped;

    int                        error_count;
    int                        pending_count;
    int                        result_count;
    int                        escaped_count;
    int unsigned               quiet_cycles = 0;
    int                        bound_settings = 0;
    // set for whole phases to run both sides without any idling
    bit                        no_idle = 1'b0;

    always #4 aclk = ~aclk;

    mandelbrot_escape_counter_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_c_real       (s_c_real),
        .s_c_imag       (s_c_imag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_escape_count (m_escape_count),
        .m_escaped      (m_escaped)
    );

    mbe_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_c_real       (s_c_real),
        .s_c_imag       (s_c_imag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_escape_count (m_escape_count),
        .m_escaped      (m_escaped),
        .error_count    (error_count),
        .pending_count  (pending_count),
        .result_count   (result_count),
        .escaped_count  (escaped_count)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 16);
        return $urandom_range(30, 120);
    endfunction

    // Mostly points near the set, where escape times vary the most; the rest
    // are full-range patterns and tiny values that exercise the floor shifts.
    function automatic point_t random_point();
        point_t      p;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            p.re = $urandom;
            p.im = $urandom;
        end else if (roll < 25) begin
            p.re = $urandom_range(0, 4095) - 32'd2048;
            p.im = $urandom_range(0, 4095) - 32'd2048;
        end else begin
            // real in [-2.25, 0.75], imaginary in [-1.5, 1.5]
            p.re = $urandom_range(0, 32'h3000_0000) - 32'h2400_0000;
            p.im = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
        end
        return p;
    endfunction

    // Offer one point and hold it until taken. Valid stays high into the
    // next item when no gap is drawn.
    task automatic send_point(input logic signed [DATA_W-1:0] re,
                              input logic signed [DATA_W-1:0] im);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            s_c_real <= $urandom;
            s_c_imag <= $urandom;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_c_real <= re;
        s_c_imag <= im;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, then wait until every predicted result has come back
    task automatic finish_burst();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write max_iter (junk in the unused upper bits), then read it back
    task automatic program_bound(input logic [COUNT_W-1:0] bound);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MAX_ITER_ADDR;
        pwdata <= {16'($urandom), bound};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        bound_settings++;
    endtask

    // Result side back-pressure: runs of ready broken by random stalls
    initial begin : result_sink
        int unsigned run_len;
        int unsigned stall_len;
        forever begin
            run_len = $urandom_range(1, 24);
            stall_len = pick_gap();
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            if (stall_len != 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves an item
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[%0t] watchdog: no item moved for %0d cycles, %0d results outstanding",
                 $realtime, WATCHDOG_LIMIT, pending_count);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned random_bounds [RANDOM_PHASES];
        point_t      p;
        int          phase;

        random_bounds = '{1, 0, 2, 5, 16, 31, 64, 128, 255, 1000, 0};
        random_bounds[RANDOM_PHASES-1] = $urandom_range(3, 400);

        // Hold reset low from the start, then release it once
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed points at the reset bound of 16
        send_point(0, 0);                 // origin never escapes
        send_point(Q_MAX, Q_MAX);         // field extremes, escape on the first step
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MAX, Q_MIN);
        send_point(Q_MIN, Q_MAX);
        send_point(-ONE, 0);              // period-two orbit
        send_point(-TWO, 0);              // tip of the set, stays at |z| = 2
        send_point(QUARTER, 0);           // cusp, slow convergence
        send_point(QUARTER + (ONE >>> 6), 0);  // just outside the cusp, late escape
        send_point(0, ONE);               // orbit through -1+i and -i
        send_point(TWO, 0);
        send_point(-1, -1);               // one LSB below zero: floor rounding
        send_point(1, -1);
        send_point(-(HALF + QUARTER), ONE >>> 3);
        send_point(32'sh5555_5555, 32'shAAAA_AAAA);
        send_point(32'shAAAA_AAAA, 32'sh5555_5555);
        finish_burst();

        // A bound of zero runs no step at all
        program_bound(16'd0);
        send_point(0, 0);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, 0);
        finish_burst();

        // Single step: every point takes one step before the test
        program_bound(16'd1);
        send_point(0, 0);
        send_point(TWO, 0);
        send_point(HALF, HALF);
        finish_burst();

        // Widest bound: only a handful of points, two of them run all steps
        program_bound(16'hFFFF);
        send_point(0, 0);
        send_point(-ONE, 0);
        send_point(QUARTER + (ONE >>> 6), 0);
        send_point(Q_MAX, Q_MIN);
        finish_burst();

        // Random points over a spread of bounds
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            no_idle = (phase % 4 == 3);
            program_bound(COUNT_W'(random_bounds[phase]));
            repeat (PHASE_ITEMS) begin
                p = random_point();
                send_point(p.re, p.im);
            end
            finish_burst();
        end
        no_idle = 1'b0;

        // Catch any stray result before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d points (%0d escaped) over %0d max_iter settings,",
                 result_count, escaped_count, bound_settings);
        $display("bounds from 0 to 65535 with random gaps and result stalls.");
        if (error_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
design/mbe_pkg.sv
design/mbe_datapath.sv
design/mbe_ctrl.sv
design/mandelbrot_escape_counter_unit.sv
tb/mbe_checker.sv
tb/testbench.sv
